// File: src/rgb_to_hsv_pixel_defines.svh
// ----------------------------------------------------------------------------
// RGB to HSV pixel converter: assertion macros
// Shared property forms for the concurrent checks of the converter.
// ----------------------------------------------------------------------------
`ifndef RGB_TO_HSV_PIXEL_DEFINES_SVH
`define RGB_TO_HSV_PIXEL_DEFINES_SVH

// The antecedent implies the consequent in the same cycle.
`define RHSV_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The antecedent implies the consequent in the next cycle.
`define RHSV_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/rhsv_pkg.sv
// ----------------------------------------------------------------------------
// RGB to HSV pixel converter: package
// Widths, constants, the divider work item and the restoring division steps.
// ----------------------------------------------------------------------------
`default_nettype none

package rhsv_pkg;

	localparam int ChanW     = 8;
	localparam int HueW      = 9;
	localparam int SatW      = 17;
	localparam int SatRemW   = 25;
	localparam int HueRemW   = 18;
	localparam int DivW      = 9;
	localparam int TermW     = 20;
	localparam int DivStages = 9;

	localparam logic [HueW-1:0]  HueWrap = 9'd360;
	localparam logic [HueW-1:0]  HueMax  = 9'd359;
	localparam logic [SatW-1:0]  SatOne  = 17'd65536;
	localparam logic [DivW-1:0]  DivOne  = 9'd1;

	// Twice the hue offset of each sector.
	localparam logic [9:0] Base2Red     = 10'd0;
	localparam logic [9:0] Base2RedWrap = 10'd720;
	localparam logic [9:0] Base2Green   = 10'd240;
	localparam logic [9:0] Base2Blue    = 10'd480;

	localparam logic signed [TermW-1:0] HueSlope2 = 20'sd120;

	typedef struct packed {
		logic [SatRemW-1:0] sat_rem;
		logic [DivW-1:0]    sat_div;
		logic [SatW-1:0]    sat_q;
		logic [HueRemW-1:0] hue_rem;
		logic [DivW-1:0]    hue_div;
		logic [HueW-1:0]    hue_q;
		logic [ChanW-1:0]   bright;
		logic               frame_end;
	} div_work_t;

	typedef struct packed {
		logic [SatRemW-1:0] rem;
		logic               qbit;
	} sat_step_t;

	typedef struct packed {
		logic [HueRemW-1:0] rem;
		logic               qbit;
	} hue_step_t;

	function automatic sat_step_t sat_step(input logic [SatRemW-1:0] rem,
			input logic [DivW-1:0] divisor, input logic [4:0] sh);
		logic [SatRemW-1:0] dsh;
		sat_step_t          res;
		dsh = SatRemW'(divisor) << sh;
		if (rem >= dsh) begin
			res.rem  = rem - dsh;
			res.qbit = 1'b1;
		end else begin
			res.rem  = rem;
			res.qbit = 1'b0;
		end
		return res;
	endfunction

	function automatic hue_step_t hue_step(input logic [HueRemW-1:0] rem,
			input logic [DivW-1:0] divisor, input logic [3:0] sh);
		logic [HueRemW-1:0] dsh;
		hue_step_t          res;
		dsh = HueRemW'(divisor) << sh;
		if (rem >= dsh) begin
			res.rem  = rem - dsh;
			res.qbit = 1'b1;
		end else begin
			res.rem  = rem;
			res.qbit = 1'b0;
		end
		return res;
	endfunction

endpackage

`default_nettype wire

// File: src/rhsv_if.sv
// ----------------------------------------------------------------------------
// RGB to HSV pixel converter: channel interfaces
// Valid/ready channels for the incoming pixel and the outgoing HSV result.
// ----------------------------------------------------------------------------
`default_nettype none

interface rhsv_pix_if;
	import rhsv_pkg::*;

	logic             valid;
	logic             ready;
	logic [ChanW-1:0] red;
	logic [ChanW-1:0] green;
	logic [ChanW-1:0] blue;
	logic             frame_end;

	modport source (output valid, red, green, blue, frame_end, input ready);
	modport sink (input valid, red, green, blue, frame_end, output ready);
endinterface

interface rhsv_hsv_if;
	import rhsv_pkg::*;

	logic             valid;
	logic             ready;
	logic [HueW-1:0]  hue;
	logic [SatW-1:0]  saturation;
	logic [ChanW-1:0] brightness;
	logic             frame_end_out;

	modport source (output valid, hue, saturation, brightness, frame_end_out, input ready);
	modport sink (input valid, hue, saturation, brightness, frame_end_out, output ready);
endinterface

`default_nettype wire

// File: src/rhsv_div_stage.sv
// ----------------------------------------------------------------------------
// RGB to HSV pixel converter: divider stage
// One registered stage of the two restoring dividers: two saturation
// quotient bits (one in the last stage) and one hue quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rhsv_div_stage #(
	parameter int unsigned STAGE = 0
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire rhsv_pkg::div_work_t in_work,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output rhsv_pkg::div_work_t     out_work
);
	import rhsv_pkg::*;

	localparam int  SatHi  = SatW - 1 - 2 * int'(STAGE);
	localparam bit  TwoSat = (SatHi > 0);
	localparam int  SatLo  = TwoSat ? SatHi - 1 : SatHi;
	localparam int  HueBit = HueW - 1 - int'(STAGE);

	div_work_t nxt;
	sat_step_t st_a;
	sat_step_t st_b;
	hue_step_t ht;
	div_work_t work_q;
	logic      valid_q;

	always_comb begin
		nxt  = in_work;
		st_a = sat_step(in_work.sat_rem, in_work.sat_div, 5'(SatHi));
		nxt.sat_rem = st_a.rem;
		nxt.sat_q[SatHi] = st_a.qbit;
		st_b = sat_step(st_a.rem, in_work.sat_div, 5'(SatLo));
		if (TwoSat) begin
			nxt.sat_rem = st_b.rem;
			nxt.sat_q[SatLo] = st_b.qbit;
		end
		ht = hue_step(in_work.hue_rem, in_work.hue_div, 4'(HueBit));
		nxt.hue_rem = ht.rem;
		nxt.hue_q[HueBit] = ht.qbit;
	end

	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			work_q <= nxt;
		end
	end

	assign out_valid = valid_q;
	assign out_work  = work_q;

endmodule

`default_nettype wire

// File: src/rgb_to_hsv_pixel.sv
// ----------------------------------------------------------------------------
// RGB to HSV pixel converter
// Converts one 8-bit RGB pixel per clock, unless stalled, into HSV values.
//
// Pixels arrive on the pix channel and results leave on the hsv channel;
// both are valid/ready channels and a transaction takes place on a rising
// edge with valid and ready high. Each pixel gives exactly one result, in
// order, with the frame-end mark copied through.
// A pixel passes from the edge that accepts it to the edge at which its
// result first shows valid through twelve register stages:
// one for the channel extremes, one for the dividends and divisors, nine
// for the pipelined restoring dividers and one for the hue wrap.
// Every stage has its own valid bit and moves on when it is empty or its
// successor moves, so bubbles close up. Throughput is one pixel per cycle
// until the receiver stalls; then the stages fill and pix.ready falls only
// once every stage holds a transaction; nothing is dropped or repeated.
// Reset clears all valid bits at once; the block accepts pixels as soon as
// reset is released.
// ----------------------------------------------------------------------------
`default_nettype none
`include "rgb_to_hsv_pixel_defines.svh"

module rgb_to_hsv_pixel (
	input  wire logic clk,
	input  wire logic arst_n,
	rhsv_pix_if.sink  pix,
	rhsv_hsv_if.source hsv
);
	import rhsv_pkg::*;

	// Stage 1: extremes and sector.
	logic [ChanW-1:0] max_rg, min_rg, mx, mn;
	logic             r_max, g_max;
	logic             valid_s1, rdy_s1;
	logic [ChanW-1:0] red_s1, green_s1, blue_s1, mx_s1, d_s1;
	logic             r_max_s1, g_max_s1, gb_s1, fe_s1;

	always_comb begin
		max_rg = (pix.red >= pix.green) ? pix.red : pix.green;
		min_rg = (pix.red <= pix.green) ? pix.red : pix.green;
		mx     = (max_rg >= pix.blue) ? max_rg : pix.blue;
		mn     = (min_rg <= pix.blue) ? min_rg : pix.blue;
		r_max  = (pix.red >= pix.green) && (pix.red >= pix.blue);
		g_max  = !r_max && (pix.green >= pix.blue);
	end

	// Stage 2: dividends and divisors.
	logic                    valid_s2, rdy_s2;
	div_work_t               work_s2;
	div_work_t               work_n2;
	logic signed [ChanW:0]   num;
	logic [9:0]              base2;
	logic [TermW-1:0]        t_full;

	always_comb begin
		priority if (r_max_s1) begin
			num   = $signed({1'b0, green_s1}) - $signed({1'b0, blue_s1});
			base2 = gb_s1 ? Base2Red : Base2RedWrap;
		end else if (g_max_s1) begin
			num   = $signed({1'b0, blue_s1}) - $signed({1'b0, red_s1});
			base2 = Base2Green;
		end else begin
			num   = $signed({1'b0, red_s1}) - $signed({1'b0, green_s1});
			base2 = Base2Blue;
		end
		t_full = TermW'(base2) * TermW'(d_s1) + TermW'($signed(num) * HueSlope2)
			+ TermW'(d_s1);

		work_n2           = '0;
		work_n2.bright    = mx_s1;
		work_n2.frame_end = fe_s1;
		work_n2.sat_rem   = {d_s1, {(SatRemW - ChanW){1'b0}}} + SatRemW'(mx_s1);
		work_n2.sat_div   = (mx_s1 == '0) ? DivOne : {mx_s1, 1'b0};
		if (d_s1 == '0) begin
			work_n2.hue_rem = '0;
			work_n2.hue_div = DivOne;
		end else begin
			work_n2.hue_rem = t_full[HueRemW-1:0];
			work_n2.hue_div = {d_s1, 1'b0};
		end
	end

	// Divider pipeline.
	div_work_t work_d  [DivStages+1];
	logic      valid_d [DivStages+1];
	logic      ready_d [DivStages+1];

	assign work_d[0]  = work_s2;
	assign valid_d[0] = valid_s2;

	for (genvar k = 0; k < DivStages; k++) begin : g_div
		rhsv_div_stage #(
			.STAGE(k)
		) u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (valid_d[k]),
			.in_ready (ready_d[k]),
			.in_work  (work_d[k]),
			.out_valid(valid_d[k+1]),
			.out_ready(ready_d[k+1]),
			.out_work (work_d[k+1])
		);
	end

	// Stage 3: hue wrap and output register.
	logic             valid_s3, rdy_s3;
	logic [HueW-1:0]  hue_s3;
	logic [SatW-1:0]  sat_s3;
	logic [ChanW-1:0] bright_s3;
	logic             fe_s3;
	logic [HueW-1:0]  hue_wrapped;

	assign hue_wrapped = (work_d[DivStages].hue_q > HueMax)
		? work_d[DivStages].hue_q - HueWrap : work_d[DivStages].hue_q;

	assign rdy_s3              = !valid_s3 || hsv.ready;
	assign ready_d[DivStages]  = rdy_s3;
	assign rdy_s2              = !valid_s2 || ready_d[0];
	assign rdy_s1              = !valid_s1 || rdy_s2;
	assign pix.ready           = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (rdy_s1) valid_s1 <= pix.valid;
			if (rdy_s2) valid_s2 <= valid_s1;
			if (rdy_s3) valid_s3 <= valid_d[DivStages];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && pix.valid) begin
			red_s1   <= pix.red;
			green_s1 <= pix.green;
			blue_s1  <= pix.blue;
			mx_s1    <= mx;
			d_s1     <= mx - mn;
			r_max_s1 <= r_max;
			g_max_s1 <= g_max;
			gb_s1    <= (pix.green >= pix.blue);
			fe_s1    <= pix.frame_end;
		end
		if (rdy_s2 && valid_s1) begin
			work_s2 <= work_n2;
		end
		if (rdy_s3 && valid_d[DivStages]) begin
			hue_s3    <= hue_wrapped;
			sat_s3    <= work_d[DivStages].sat_q;
			bright_s3 <= work_d[DivStages].bright;
			fe_s3     <= work_d[DivStages].frame_end;
		end
	end

	assign hsv.valid         = valid_s3;
	assign hsv.hue           = hue_s3;
	assign hsv.saturation    = sat_s3;
	assign hsv.brightness    = bright_s3;
	assign hsv.frame_end_out = fe_s3;

	`RHSV_ASSERT_SAME(a_hue_range, hsv.valid, hsv.hue <= HueMax, "hue out of range")
	`RHSV_ASSERT_SAME(a_sat_range, hsv.valid, hsv.saturation <= SatOne, "saturation above one")
	`RHSV_ASSERT_SAME(a_grey_hue, hsv.valid && hsv.saturation == '0, hsv.hue == '0, "grey hue")
	`RHSV_ASSERT_SAME(a_stall_full, !pix.ready, hsv.valid, "input stalled while output is empty")
	`RHSV_ASSERT_NEXT(a_enter, pix.valid && pix.ready, valid_s1, "accepted transaction lost")

endmodule

`default_nettype wire
